// File: rtl/one_wire_bus_master_core_defines.svh
// ----------------------------------------------------------------------------
// one_wire_bus_master_core_defines
// Assertion macros shared by the bus master RTL.
// ----------------------------------------------------------------------------
`ifndef ONE_WIRE_BUS_MASTER_CORE_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_CORE_DEFINES_SVH

// same-cycle implication
`define OWBM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define OWBM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg
// Types, codes and constants of the 1-Wire bus master.
// ----------------------------------------------------------------------------
package owbm_pkg;

   localparam int TICK_WIDTH_DEF = 10;
   localparam int CFG_W          = 10;
   localparam int REG_COUNT      = 8;
   localparam int ADDR_W         = 5;
   localparam int DATA_W         = 32;

   localparam logic [CFG_W-1:0] LEAD_TICKS          = 10'd10;
   localparam logic [CFG_W-1:0] WRITE_ZERO_RECOVERY = 10'd5;

   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_RESET = 2'd1;
   localparam logic [1:0] FUNC_WRITE = 2'd2;
   localparam logic [1:0] FUNC_READ  = 2'd3;

   localparam logic [2:0] REG_RESET_LOW     = 3'd0;
   localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
   localparam logic [2:0] REG_RESET_TAIL    = 3'd2;
   localparam logic [2:0] REG_WRITE_ONE     = 3'd3;
   localparam logic [2:0] REG_WRITE_ZERO    = 3'd4;
   localparam logic [2:0] REG_READ_LOW      = 3'd5;
   localparam logic [2:0] REG_READ_SAMPLE   = 3'd6;
   localparam logic [2:0] REG_SLOT_TAIL     = 3'd7;

   localparam logic [CFG_W-1:0] RESET_LOW_DEF     = 10'd520;
   localparam logic [CFG_W-1:0] PRESENCE_WAIT_DEF = 10'd57;
   localparam logic [CFG_W-1:0] RESET_TAIL_DEF    = 10'd200;
   localparam logic [CFG_W-1:0] WRITE_ONE_DEF     = 10'd6;
   localparam logic [CFG_W-1:0] WRITE_ZERO_DEF    = 10'd60;
   localparam logic [CFG_W-1:0] READ_LOW_DEF      = 10'd2;
   localparam logic [CFG_W-1:0] READ_SAMPLE_DEF   = 10'd8;
   localparam logic [CFG_W-1:0] SLOT_TAIL_DEF     = 10'd55;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_LEAD,
      PH_RST_LOW,
      PH_RST_WAIT,
      PH_RST_TAIL,
      PH_WR_LOW,
      PH_WR_REC,
      PH_RD_LOW,
      PH_RD_WAIT,
      PH_RD_TAIL
   } owbm_phase_type;

   typedef struct packed {
      logic [CFG_W-1:0] reset_low;
      logic [CFG_W-1:0] presence_wait;
      logic [CFG_W-1:0] reset_tail;
      logic [CFG_W-1:0] write_one_low;
      logic [CFG_W-1:0] write_zero_low;
      logic [CFG_W-1:0] read_low;
      logic [CFG_W-1:0] read_sample;
      logic [CFG_W-1:0] slot_tail;
   } owbm_cfg_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic       presence;
      logic [7:0] rx_byte;
   } owbm_result_type;

endpackage

// File: rtl/owbm_channels.sv
// ----------------------------------------------------------------------------
// owbm_channels
// Valid/ready channel interfaces for tick items and result items.
// ----------------------------------------------------------------------------
interface owbm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] tx_byte;
   logic       line_level;

   modport source (output valid, output func, output tx_byte, output line_level,
                   input ready);
   modport sink (input valid, input func, input tx_byte, input line_level,
                 output ready);
endinterface

interface owbm_rsp_if;
   logic       valid;
   logic       ready;
   logic       drive_low;
   logic       busy_res;
   logic       done_res;
   logic       presence;
   logic [7:0] rx_byte;

   modport source (output valid, output drive_low, output busy_res, output done_res,
                   output presence, output rx_byte, input ready);
   modport sink (input valid, input drive_low, input busy_res, input done_res,
                 input presence, input rx_byte, output ready);
endinterface

// File: rtl/owbm_csr.sv
// ----------------------------------------------------------------------------
// owbm_csr
// APB-style register file holding the slot timing registers.
// ----------------------------------------------------------------------------
module owbm_csr #(
   parameter int TICK_WIDTH = owbm_pkg::TICK_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [owbm_pkg::ADDR_W-1:0] paddr,
   input  logic [owbm_pkg::DATA_W-1:0] pwdata,
   output logic [owbm_pkg::DATA_W-1:0] prdata,
   output logic                        pready,
   output owbm_pkg::owbm_cfg_type      cfg
);

   localparam int CW = owbm_pkg::CFG_W;
   localparam logic [CW-1:0] TICK_MASK = CW'((64'(1) << TICK_WIDTH) - 64'(1));

   logic [CW-1:0] regs_ff [owbm_pkg::REG_COUNT];
   logic [2:0]    index;
   logic          wr_en;

   assign index  = paddr[4:2];
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff[owbm_pkg::REG_RESET_LOW]     <= owbm_pkg::RESET_LOW_DEF & TICK_MASK;
         regs_ff[owbm_pkg::REG_PRESENCE_WAIT] <= owbm_pkg::PRESENCE_WAIT_DEF & TICK_MASK;
         regs_ff[owbm_pkg::REG_RESET_TAIL]    <= owbm_pkg::RESET_TAIL_DEF & TICK_MASK;
         regs_ff[owbm_pkg::REG_WRITE_ONE]     <= owbm_pkg::WRITE_ONE_DEF & TICK_MASK;
         regs_ff[owbm_pkg::REG_WRITE_ZERO]    <= owbm_pkg::WRITE_ZERO_DEF & TICK_MASK;
         regs_ff[owbm_pkg::REG_READ_LOW]      <= owbm_pkg::READ_LOW_DEF & TICK_MASK;
         regs_ff[owbm_pkg::REG_READ_SAMPLE]   <= owbm_pkg::READ_SAMPLE_DEF & TICK_MASK;
         regs_ff[owbm_pkg::REG_SLOT_TAIL]     <= owbm_pkg::SLOT_TAIL_DEF & TICK_MASK;
      end else if (wr_en) begin
         regs_ff[index] <= pwdata[CW-1:0] & TICK_MASK;
      end
   end

   assign prdata = owbm_pkg::DATA_W'(regs_ff[index]);

   assign cfg.reset_low      = regs_ff[owbm_pkg::REG_RESET_LOW];
   assign cfg.presence_wait  = regs_ff[owbm_pkg::REG_PRESENCE_WAIT];
   assign cfg.reset_tail     = regs_ff[owbm_pkg::REG_RESET_TAIL];
   assign cfg.write_one_low  = regs_ff[owbm_pkg::REG_WRITE_ONE];
   assign cfg.write_zero_low = regs_ff[owbm_pkg::REG_WRITE_ZERO];
   assign cfg.read_low       = regs_ff[owbm_pkg::REG_READ_LOW];
   assign cfg.read_sample    = regs_ff[owbm_pkg::REG_READ_SAMPLE];
   assign cfg.slot_tail      = regs_ff[owbm_pkg::REG_SLOT_TAIL];

endmodule

// File: rtl/owbm_engine.sv
// ----------------------------------------------------------------------------
// owbm_engine
// Sequencer state and one-tick next-state logic for reset, write and read.
// ----------------------------------------------------------------------------
module owbm_engine #(
   parameter int TICK_WIDTH = owbm_pkg::TICK_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [1:0]                func,
   input  logic [7:0]                tx_byte,
   input  logic                      line_level,
   input  owbm_pkg::owbm_cfg_type    cfg,
   output owbm_pkg::owbm_result_type result,
   output logic                      idle
);

   localparam int CW    = owbm_pkg::CFG_W;
   localparam int CMP_W = ((TICK_WIDTH > CW) ? TICK_WIDTH : CW) + 1;

   typedef struct packed {
      logic       found;
      logic [2:0] k;
      logic       bit_val;
   } wr_scan_type;

   owbm_pkg::owbm_phase_type phase_ff, phase_in;
   logic [TICK_WIDTH-1:0]    tick_ff, tick_in;
   logic [2:0]               bit_ff, bit_in;
   logic [7:0]               shift_ff, shift_in;
   logic                     pres_ff, pres_in;
   logic [1:0]               cmd_ff, cmd_in;
   logic [7:0]               rx_ff, rx_in;
   logic                     done;

   logic [CW-1:0]    len_v;
   logic [CMP_W-1:0] len_ext, tick_ext, tick_nx;
   logic             end_run, end_sample;
   logic             one_z, zero_z, tail_z, rlow_z;
   logic [2:0]       wr_b;
   logic [7:0]       wr_s, rd_s;
   wr_scan_type      wr_scan;
   owbm_pkg::owbm_phase_type wr_phase;

   function automatic wr_scan_type scan_bits(input logic [2:0] b, input logic [7:0] s,
                                             input logic skip_ones);
      wr_scan_type r;
      r = '0;
      for (int k = 0; k < 8; k++) begin
         if (!r.found && ((4'(k) + {1'b0, b}) <= 4'd7) && !(s[k] && skip_ones)) begin
            r.found   = 1'b1;
            r.k       = 3'(k);
            r.bit_val = s[k];
         end
      end
      return r;
   endfunction

   assign one_z  = (cfg.write_one_low == '0);
   assign zero_z = (cfg.write_zero_low == '0);
   assign tail_z = (cfg.slot_tail == '0);
   assign rlow_z = (cfg.read_low == '0);

   always_comb begin
      case (phase_ff)
         owbm_pkg::PH_LEAD:     len_v = owbm_pkg::LEAD_TICKS;
         owbm_pkg::PH_RST_LOW:  len_v = cfg.reset_low;
         owbm_pkg::PH_RST_WAIT: len_v = cfg.presence_wait;
         owbm_pkg::PH_RST_TAIL: len_v = cfg.reset_tail;
         owbm_pkg::PH_WR_LOW:   len_v = shift_ff[0] ? cfg.write_one_low : cfg.write_zero_low;
         owbm_pkg::PH_WR_REC:   len_v = shift_ff[0] ? cfg.slot_tail
                                                    : owbm_pkg::WRITE_ZERO_RECOVERY;
         owbm_pkg::PH_RD_LOW:   len_v = cfg.read_low;
         owbm_pkg::PH_RD_WAIT:  len_v = cfg.read_sample;
         owbm_pkg::PH_RD_TAIL:  len_v = cfg.slot_tail;
         default:               len_v = '0;
      endcase
   end

   assign len_ext    = CMP_W'(len_v);
   assign tick_ext   = CMP_W'(tick_ff);
   assign tick_nx    = tick_ext + CMP_W'(1);
   assign end_run    = (tick_nx >= len_ext);
   assign end_sample = (tick_ext >= len_ext);

   assign wr_b    = (phase_ff == owbm_pkg::PH_LEAD) ? 3'd0 : bit_ff + 3'd1;
   assign wr_s    = (phase_ff == owbm_pkg::PH_LEAD) ? shift_ff : (shift_ff >> 1);
   assign wr_scan = scan_bits(wr_b, wr_s, one_z && tail_z);
   assign rd_s    = {line_level, shift_ff[7:1]};

   always_comb begin
      if (wr_scan.bit_val) begin
         wr_phase = one_z ? owbm_pkg::PH_WR_REC : owbm_pkg::PH_WR_LOW;
      end else begin
         wr_phase = zero_z ? owbm_pkg::PH_WR_REC : owbm_pkg::PH_WR_LOW;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff + TICK_WIDTH'(1);
      bit_in   = bit_ff;
      shift_in = shift_ff;
      pres_in  = pres_ff;
      cmd_in   = cmd_ff;
      rx_in    = rx_ff;
      done     = 1'b0;
      case (phase_ff)
         owbm_pkg::PH_IDLE: begin
            tick_in = tick_ff;
            if (func != owbm_pkg::FUNC_TICK) begin
               cmd_in   = func;
               bit_in   = 3'd0;
               shift_in = (func == owbm_pkg::FUNC_WRITE) ? tx_byte : 8'd0;
               phase_in = owbm_pkg::PH_LEAD;
               tick_in  = '0;
            end
         end
         owbm_pkg::PH_RST_WAIT: begin
            if (end_sample) begin
               tick_in = '0;
               pres_in = !line_level;
               if (cfg.reset_tail == '0) begin
                  phase_in = owbm_pkg::PH_IDLE;
                  done     = 1'b1;
               end else begin
                  phase_in = owbm_pkg::PH_RST_TAIL;
               end
            end
         end
         owbm_pkg::PH_RD_WAIT: begin
            if (end_sample) begin
               tick_in  = '0;
               shift_in = rd_s;
               if (!tail_z) begin
                  phase_in = owbm_pkg::PH_RD_TAIL;
               end else if (bit_ff == 3'd7) begin
                  rx_in    = rd_s;
                  phase_in = owbm_pkg::PH_IDLE;
                  done     = 1'b1;
               end else begin
                  bit_in   = bit_ff + 3'd1;
                  phase_in = rlow_z ? owbm_pkg::PH_RD_WAIT : owbm_pkg::PH_RD_LOW;
               end
            end
         end
         default: begin
            if (end_run) begin
               tick_in = '0;
               case (phase_ff)
                  owbm_pkg::PH_LEAD: begin
                     case (cmd_ff)
                        owbm_pkg::FUNC_RESET: begin
                           phase_in = (cfg.reset_low == '0) ? owbm_pkg::PH_RST_WAIT
                                                            : owbm_pkg::PH_RST_LOW;
                        end
                        owbm_pkg::FUNC_WRITE: begin
                           if (wr_scan.found) begin
                              bit_in   = wr_b + wr_scan.k;
                              shift_in = wr_s >> wr_scan.k;
                              phase_in = wr_phase;
                           end else begin
                              phase_in = owbm_pkg::PH_IDLE;
                              done     = 1'b1;
                           end
                        end
                        default: begin
                           phase_in = rlow_z ? owbm_pkg::PH_RD_WAIT : owbm_pkg::PH_RD_LOW;
                        end
                     endcase
                  end
                  owbm_pkg::PH_RST_LOW: phase_in = owbm_pkg::PH_RST_WAIT;
                  owbm_pkg::PH_RD_LOW:  phase_in = owbm_pkg::PH_RD_WAIT;
                  owbm_pkg::PH_WR_LOW, owbm_pkg::PH_WR_REC: begin
                     if (phase_ff == owbm_pkg::PH_WR_LOW && !(shift_ff[0] && tail_z)) begin
                        phase_in = owbm_pkg::PH_WR_REC;
                     end else if (bit_ff == 3'd7) begin
                        shift_in = shift_ff >> 1;
                        phase_in = owbm_pkg::PH_IDLE;
                        done     = 1'b1;
                     end else if (wr_scan.found) begin
                        bit_in   = wr_b + wr_scan.k;
                        shift_in = wr_s >> wr_scan.k;
                        phase_in = wr_phase;
                     end else begin
                        shift_in = wr_s;
                        phase_in = owbm_pkg::PH_IDLE;
                        done     = 1'b1;
                     end
                  end
                  owbm_pkg::PH_RD_TAIL: begin
                     if (bit_ff == 3'd7) begin
                        rx_in    = shift_ff;
                        phase_in = owbm_pkg::PH_IDLE;
                        done     = 1'b1;
                     end else begin
                        bit_in   = bit_ff + 3'd1;
                        phase_in = rlow_z ? owbm_pkg::PH_RD_WAIT : owbm_pkg::PH_RD_LOW;
                     end
                  end
                  default: begin
                     phase_in = owbm_pkg::PH_IDLE;
                     done     = 1'b1;
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= owbm_pkg::PH_IDLE;
         tick_ff  <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         pres_ff  <= 1'b0;
         cmd_ff   <= owbm_pkg::FUNC_TICK;
         rx_ff    <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         pres_ff  <= pres_in;
         cmd_ff   <= cmd_in;
         rx_ff    <= rx_in;
      end
   end

   assign result.drive_low = (phase_in == owbm_pkg::PH_RST_LOW) ||
                             (phase_in == owbm_pkg::PH_WR_LOW)  ||
                             (phase_in == owbm_pkg::PH_RD_LOW);
   assign result.busy_res  = (phase_in != owbm_pkg::PH_IDLE);
   assign result.done_res  = done;
   assign result.presence  = pres_in;
   assign result.rx_byte   = rx_in;
   assign idle             = (phase_ff == owbm_pkg::PH_IDLE);

endmodule

// File: rtl/one_wire_bus_master_core.sv
// The result of an item is in the output register in the cycle after it is accepted.
// Throughput: one item per cycle while input is not stalled; the sequencer advances once per accepted item.
// The output register stalls input only while a result waits and the sink is not ready.
// Reset: synchronous; the sequencer returns to idle with cleared flags and read byte,
// and the timing registers return to their defaults.
// ----------------------------------------------------------------------------
// one_wire_bus_master_core
// 1-Wire bus master: tick-driven reset, byte write and byte read sequences.
// ----------------------------------------------------------------------------
`include "one_wire_bus_master_core_defines.svh"

module one_wire_bus_master_core #(
   parameter int TICK_WIDTH = owbm_pkg::TICK_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   owbm_req_if.sink                    req,
   owbm_rsp_if.source                  rsp,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [owbm_pkg::ADDR_W-1:0] paddr,
   input  logic [owbm_pkg::DATA_W-1:0] pwdata,
   output logic [owbm_pkg::DATA_W-1:0] prdata,
   output logic                        pready
);

   owbm_pkg::owbm_cfg_type    cfg;
   owbm_pkg::owbm_result_type result;
   owbm_pkg::owbm_result_type rsp_data_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      accept;
   logic                      idle;

   owbm_csr #(
      .TICK_WIDTH (TICK_WIDTH)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   owbm_engine #(
      .TICK_WIDTH (TICK_WIDTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .func       (req.func),
      .tx_byte    (req.tx_byte),
      .line_level (req.line_level),
      .cfg        (cfg),
      .result     (result),
      .idle       (idle)
   );

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.drive_low = rsp_data_ff.drive_low;
   assign rsp.busy_res  = rsp_data_ff.busy_res;
   assign rsp.done_res  = rsp_data_ff.done_res;
   assign rsp.presence  = rsp_data_ff.presence;
   assign rsp.rx_byte   = rsp_data_ff.rx_byte;

   `OWBM_ASSERT_NXT(a_start_busy, clock, reset, accept && idle && req.func != owbm_pkg::FUNC_TICK, rsp.valid && rsp.busy_res, "command from idle did not start a sequence")
   `OWBM_ASSERT_IMP(a_done_idle, clock, reset, rsp.valid && rsp.done_res, !rsp.busy_res, "done reported while still busy")
   `OWBM_ASSERT_IMP(a_drive_busy, clock, reset, rsp.valid && rsp.drive_low, rsp.busy_res, "bus driven low outside a sequence")
   `OWBM_ASSERT_IMP(a_ready_free, clock, reset, !rsp.valid || rsp.ready, req.ready, "input stalled with free output register")

endmodule

// File: bench/one_wire_bus_master_core_test.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_core_test
// Self-checking bench for the 1-Wire bus master core. A sequencer model in
// the bench predicts every result beat; a simple slave answers presence and
// read slots from the predicted slot position. Covers idle ticks, register
// defaults and read-back, minimum, zero and maximum register values, commands
// while busy, sink hold-off and random command streams under random source
// and sink stalls.
// ----------------------------------------------------------------------------
module one_wire_bus_master_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW          = owbm_pkg::CFG_W;
   localparam int DW          = owbm_pkg::DATA_W;
   localparam int ITEM_TARGET = 900;

   typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_PATTERN} sink_style_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          psel;
   logic                          penable;
   logic                          pwrite;
   logic [owbm_pkg::ADDR_W-1:0]   paddr;
   logic [DW-1:0]                 pwdata;
   logic [DW-1:0]                 prdata;
   logic                          pready;

   owbm_req_if req();
   owbm_rsp_if rsp();

   one_wire_bus_master_core i_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .rsp     (rsp),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // sequencer model state
   logic [CW-1:0]             timing [owbm_pkg::REG_COUNT];
   owbm_pkg::owbm_phase_type  seq_phase;
   logic [CW-1:0]             seq_ticks;
   logic [2:0]                seq_bit;
   logic [7:0]                seq_shift;
   logic                      seq_presence;
   logic [1:0]                seq_cmd;
   logic [7:0]                seq_rx;
   logic                      seq_done;

   owbm_pkg::owbm_result_type expected_results [$];
   int                        mismatch_count = 0;
   int                        items_sent = 0;
   int                        burst_left = 0;
   bit                        gaps_on = 1'b0;
   sink_style_type            sink_style = SINK_OPEN;
   int                        sink_count = 0;
   int                        hold_request = 0;
   int                        hold_left = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #1ms;
      $display("Regression FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- model

   function automatic void seq_reset();
      timing[owbm_pkg::REG_RESET_LOW]     = owbm_pkg::RESET_LOW_DEF;
      timing[owbm_pkg::REG_PRESENCE_WAIT] = owbm_pkg::PRESENCE_WAIT_DEF;
      timing[owbm_pkg::REG_RESET_TAIL]    = owbm_pkg::RESET_TAIL_DEF;
      timing[owbm_pkg::REG_WRITE_ONE]     = owbm_pkg::WRITE_ONE_DEF;
      timing[owbm_pkg::REG_WRITE_ZERO]    = owbm_pkg::WRITE_ZERO_DEF;
      timing[owbm_pkg::REG_READ_LOW]      = owbm_pkg::READ_LOW_DEF;
      timing[owbm_pkg::REG_READ_SAMPLE]   = owbm_pkg::READ_SAMPLE_DEF;
      timing[owbm_pkg::REG_SLOT_TAIL]     = owbm_pkg::SLOT_TAIL_DEF;
      seq_phase    = owbm_pkg::PH_IDLE;
      seq_ticks    = '0;
      seq_bit      = '0;
      seq_shift    = '0;
      seq_presence = 1'b0;
      seq_cmd      = owbm_pkg::FUNC_TICK;
      seq_rx       = '0;
      seq_done     = 1'b0;
   endfunction

   function automatic logic [CW-1:0] phase_ticks(owbm_pkg::owbm_phase_type p);
      case (p)
         owbm_pkg::PH_LEAD:     return owbm_pkg::LEAD_TICKS;
         owbm_pkg::PH_RST_LOW:  return timing[owbm_pkg::REG_RESET_LOW];
         owbm_pkg::PH_RST_WAIT: return timing[owbm_pkg::REG_PRESENCE_WAIT];
         owbm_pkg::PH_RST_TAIL: return timing[owbm_pkg::REG_RESET_TAIL];
         owbm_pkg::PH_WR_LOW:   return seq_shift[0] ? timing[owbm_pkg::REG_WRITE_ONE]
                                                    : timing[owbm_pkg::REG_WRITE_ZERO];
         owbm_pkg::PH_WR_REC:   return seq_shift[0] ? timing[owbm_pkg::REG_SLOT_TAIL]
                                                    : owbm_pkg::WRITE_ZERO_RECOVERY;
         owbm_pkg::PH_RD_LOW:   return timing[owbm_pkg::REG_READ_LOW];
         owbm_pkg::PH_RD_WAIT:  return timing[owbm_pkg::REG_READ_SAMPLE];
         owbm_pkg::PH_RD_TAIL:  return timing[owbm_pkg::REG_SLOT_TAIL];
         default:               return '0;
      endcase
   endfunction

   function automatic owbm_pkg::owbm_phase_type seq_next_phase(owbm_pkg::owbm_phase_type p);
      case (p)
         owbm_pkg::PH_LEAD: begin
            if (seq_cmd == owbm_pkg::FUNC_RESET) return owbm_pkg::PH_RST_LOW;
            if (seq_cmd == owbm_pkg::FUNC_WRITE) return owbm_pkg::PH_WR_LOW;
            return owbm_pkg::PH_RD_LOW;
         end
         owbm_pkg::PH_RST_LOW: return owbm_pkg::PH_RST_WAIT;
         owbm_pkg::PH_WR_LOW:  return owbm_pkg::PH_WR_REC;
         owbm_pkg::PH_WR_REC: begin
            seq_shift = seq_shift >> 1;
            if (seq_bit == 3'd7) begin
               seq_done = 1'b1;
               return owbm_pkg::PH_IDLE;
            end
            seq_bit = seq_bit + 3'd1;
            return owbm_pkg::PH_WR_LOW;
         end
         owbm_pkg::PH_RD_LOW: return owbm_pkg::PH_RD_WAIT;
         owbm_pkg::PH_RD_TAIL: begin
            if (seq_bit == 3'd7) begin
               seq_rx   = seq_shift;
               seq_done = 1'b1;
               return owbm_pkg::PH_IDLE;
            end
            seq_bit = seq_bit + 3'd1;
            return owbm_pkg::PH_RD_LOW;
         end
         default: begin
            seq_done = 1'b1;
            return owbm_pkg::PH_IDLE;
         end
      endcase
   endfunction

   // skip zero-length phases, possibly through several in one beat
   function automatic void seq_enter(owbm_pkg::owbm_phase_type p);
      owbm_pkg::owbm_phase_type nxt;
      nxt       = p;
      seq_phase = nxt;
      seq_ticks = '0;
      while (nxt != owbm_pkg::PH_IDLE && nxt != owbm_pkg::PH_RST_WAIT &&
             nxt != owbm_pkg::PH_RD_WAIT && phase_ticks(nxt) == '0) begin
         nxt       = seq_next_phase(nxt);
         seq_phase = nxt;
         seq_ticks = '0;
      end
   endfunction

   function automatic owbm_pkg::owbm_result_type seq_step(logic [1:0] code, logic [7:0] tx,
                                                          logic line);
      owbm_pkg::owbm_result_type res;
      logic [CW-1:0]             len;
      seq_done = 1'b0;
      if (seq_phase == owbm_pkg::PH_IDLE) begin
         if (code != owbm_pkg::FUNC_TICK) begin
            seq_cmd   = code;
            seq_bit   = '0;
            seq_shift = (code == owbm_pkg::FUNC_WRITE) ? tx : 8'h00;
            seq_enter(owbm_pkg::PH_LEAD);
         end
      end else begin
         len = phase_ticks(seq_phase);
         if (seq_phase == owbm_pkg::PH_RST_WAIT || seq_phase == owbm_pkg::PH_RD_WAIT) begin
            if (seq_ticks >= len) begin
               if (seq_phase == owbm_pkg::PH_RST_WAIT) begin
                  seq_presence = !line;
                  seq_enter(owbm_pkg::PH_RST_TAIL);
               end else begin
                  seq_shift = {line, seq_shift[7:1]};
                  seq_enter(owbm_pkg::PH_RD_TAIL);
               end
            end else begin
               seq_ticks = seq_ticks + 1'b1;
            end
         end else if (({1'b0, seq_ticks} + 11'd1) >= {1'b0, len}) begin
            seq_enter(seq_next_phase(seq_phase));
         end else begin
            seq_ticks = seq_ticks + 1'b1;
         end
      end
      res.drive_low = (seq_phase == owbm_pkg::PH_RST_LOW || seq_phase == owbm_pkg::PH_WR_LOW ||
                       seq_phase == owbm_pkg::PH_RD_LOW);
      res.busy_res  = (seq_phase != owbm_pkg::PH_IDLE);
      res.done_res  = seq_done;
      res.presence  = seq_presence;
      res.rx_byte   = seq_rx;
      return res;
   endfunction

   // slave answer on the bus for the coming tick
   function automatic logic bus_level(logic present, logic [7:0] slave_byte);
      case (seq_phase)
         owbm_pkg::PH_RST_WAIT: return !present;
         owbm_pkg::PH_RD_WAIT:  return slave_byte[seq_bit];
         owbm_pkg::PH_RST_LOW, owbm_pkg::PH_WR_LOW, owbm_pkg::PH_RD_LOW: return 1'b0;
         default:               return 1'b1;
      endcase
   endfunction

   function automatic logic [CW-1:0] pick_timing();
      int r;
      r = $urandom_range(99);
      if (r < 10) return '0;
      if (r < 75) return CW'($urandom_range(1, 4));
      if (r < 95) return CW'($urandom_range(5, 12));
      return CW'($urandom_range(13, 40));
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      owbm_pkg::owbm_result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result beat with nothing expected");
         end else begin
            want = expected_results.pop_front();
            if (rsp.drive_low !== want.drive_low)
               report_mismatch($sformatf("drive_low %b, want %b", rsp.drive_low, want.drive_low));
            if (rsp.busy_res !== want.busy_res)
               report_mismatch($sformatf("busy_res %b, want %b", rsp.busy_res, want.busy_res));
            if (rsp.done_res !== want.done_res)
               report_mismatch($sformatf("done_res %b, want %b", rsp.done_res, want.done_res));
            if (rsp.presence !== want.presence)
               report_mismatch($sformatf("presence %b, want %b", rsp.presence, want.presence));
            if (rsp.rx_byte !== want.rx_byte)
               report_mismatch($sformatf("rx_byte %h, want %h", rsp.rx_byte, want.rx_byte));
         end
      end
   end

   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      sink_count++;
      if (hold_left != 0) begin
         hold_left--;
         rsp.ready <= 1'b0;
      end else begin
         case (sink_style)
            SINK_OPEN:    rsp.ready <= 1'b1;
            SINK_RANDOM:  rsp.ready <= ($urandom_range(99) >= 30);
            SINK_PATTERN: rsp.ready <= ((sink_count % 11) < 8);
            default:      rsp.ready <= 1'b1;
         endcase
      end
   end

   // ---------------------------------------------------------------- driving

   task automatic send_item(input logic [1:0] code, input logic [7:0] tx, input logic line);
      int gap;
      if (burst_left == 0) begin
         gap = gaps_on ? $urandom_range(0, 6) : 0;
         repeat (gap) begin
            @(negedge clock);
            req.valid      <= 1'b0;
            req.func       <= 2'($urandom);
            req.tx_byte    <= 8'($urandom);
            req.line_level <= 1'($urandom);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req.valid      <= 1'b1;
      req.func       <= code;
      req.tx_byte    <= tx;
      req.line_level <= line;
      do @(posedge clock); while (!req.ready);
      expected_results.push_back(seq_step(code, tx, line));
      items_sent++;
   endtask

   task automatic wait_results_drained();
      @(negedge clock);
      req.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_timing(input logic [2:0] idx, input logic [CW-1:0] value);
      logic [DW-1:0] word;
      wait_results_drained();
      word         = $urandom;
      word[CW-1:0] = value;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= word;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      timing[idx] = value;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic check_timing(input logic [2:0] idx);
      wait_results_drained();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== DW'(timing[idx]))
         report_mismatch($sformatf("register %0d reads %h, want %h", idx, prdata, timing[idx]));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_all_timing(input logic [CW-1:0] value);
      for (int i = 0; i < owbm_pkg::REG_COUNT; i++) write_timing(i[2:0], value);
   endtask

   task automatic check_all_timing();
      for (int i = 0; i < owbm_pkg::REG_COUNT; i++) check_timing(i[2:0]);
   endtask

   task automatic run_command(input logic [1:0] code, input logic [7:0] tx,
                              input logic [7:0] slave_byte, input logic present,
                              input int noise_pct, input int busy_pct);
      logic       line;
      logic [1:0] f;
      send_item(code, tx, 1'($urandom));
      while (seq_phase != owbm_pkg::PH_IDLE) begin
         line = bus_level(present, slave_byte);
         if ($urandom_range(99) < noise_pct) line = 1'($urandom);
         f = ($urandom_range(99) < busy_pct) ? 2'($urandom_range(1, 3)) : owbm_pkg::FUNC_TICK;
         send_item(f, 8'($urandom), line);
      end
   endtask

   task automatic run_all_commands(input int busy_pct);
      run_command(owbm_pkg::FUNC_RESET, 8'h00, 8'h00, 1'b1, 0, busy_pct);
      run_command(owbm_pkg::FUNC_RESET, 8'hFF, 8'h00, 1'b0, 0, busy_pct);
      run_command(owbm_pkg::FUNC_WRITE, 8'h00, 8'h00, 1'b1, 0, busy_pct);
      run_command(owbm_pkg::FUNC_WRITE, 8'hFF, 8'h00, 1'b1, 0, busy_pct);
      run_command(owbm_pkg::FUNC_READ, 8'h00, 8'hFF, 1'b1, 0, busy_pct);
      run_command(owbm_pkg::FUNC_READ, 8'hFF, 8'h00, 1'b1, 0, busy_pct);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_idle_ticks();
      send_item(owbm_pkg::FUNC_TICK, 8'h00, 1'b0);
      send_item(owbm_pkg::FUNC_TICK, 8'hFF, 1'b1);
      send_item(owbm_pkg::FUNC_TICK, 8'h5A, 1'b0);
      send_item(owbm_pkg::FUNC_TICK, 8'hA5, 1'b1);
   endtask

   task automatic test_default_timing();
      check_all_timing();
   endtask

   task automatic test_timing_extremes();
      set_all_timing(10'd1);
      run_all_commands(0);
      set_all_timing(10'd0);
      run_all_commands(0);
      set_all_timing(10'd1023);
      check_all_timing();
      set_all_timing(10'd2);
      write_timing(owbm_pkg::REG_RESET_TAIL, 10'd0);
      write_timing(owbm_pkg::REG_READ_SAMPLE, 10'd0);
      write_timing(owbm_pkg::REG_SLOT_TAIL, 10'd0);
      check_all_timing();
      run_all_commands(0);
   endtask

   task automatic test_busy_commands();
      write_timing(owbm_pkg::REG_RESET_LOW, 10'd3);
      write_timing(owbm_pkg::REG_PRESENCE_WAIT, 10'd2);
      write_timing(owbm_pkg::REG_RESET_TAIL, 10'd3);
      write_timing(owbm_pkg::REG_WRITE_ONE, 10'd2);
      write_timing(owbm_pkg::REG_WRITE_ZERO, 10'd4);
      write_timing(owbm_pkg::REG_READ_LOW, 10'd2);
      write_timing(owbm_pkg::REG_READ_SAMPLE, 10'd2);
      write_timing(owbm_pkg::REG_SLOT_TAIL, 10'd3);
      run_command(owbm_pkg::FUNC_RESET, 8'h00, 8'h00, 1'b1, 0, 50);
      run_command(owbm_pkg::FUNC_WRITE, 8'h3C, 8'h00, 1'b1, 0, 50);
      run_command(owbm_pkg::FUNC_READ, 8'h00, 8'hC3, 1'b1, 0, 50);
   endtask

   task automatic test_back_pressure();
      sink_style   = SINK_RANDOM;
      gaps_on      = 1'b0;
      hold_request = 300;
      run_command(owbm_pkg::FUNC_WRITE, 8'h96, 8'h00, 1'b1, 10, 10);
      run_command(owbm_pkg::FUNC_READ, 8'h00, 8'h69, 1'b1, 10, 10);
      wait_results_drained();
      sink_style = SINK_PATTERN;
      gaps_on    = 1'b1;
      run_command(owbm_pkg::FUNC_RESET, 8'h00, 8'h00, 1'b1, 10, 10);
   endtask

   task automatic test_random_sequences();
      logic [1:0] code;
      do begin
         for (int i = 0; i < owbm_pkg::REG_COUNT; i++) write_timing(i[2:0], pick_timing());
         sink_style = sink_style_type'($urandom_range(0, 2));
         gaps_on    = $urandom_range(0, 3) != 0;
         repeat ($urandom_range(2, 4)) begin
            repeat ($urandom_range(0, 2))
               send_item(owbm_pkg::FUNC_TICK, 8'($urandom), 1'($urandom));
            code = 2'($urandom_range(1, 3));
            run_command(code, 8'($urandom), 8'($urandom), 1'($urandom), 10, 8);
         end
      end while (items_sent < ITEM_TARGET);
   endtask

   initial begin
      reset          = 1'b1;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      req.valid      = 1'b0;
      req.func       = owbm_pkg::FUNC_TICK;
      req.tx_byte    = '0;
      req.line_level = 1'b1;
      seq_reset();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_ticks();
      test_default_timing();
      test_timing_extremes();
      test_busy_commands();
      test_back_pressure();
      test_random_sequences();

      wait_results_drained();
      repeat (5) @(posedge clock);
      if (expected_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
